// ----- hdl/ptwa_pkg.sv -----
// ----------------------------------------------------------------------------
// ptwa_pkg
// Types and constants shared by the page table cells and the top level.
// ----------------------------------------------------------------------------
package ptwa_pkg;

	localparam logic [2:0] ACT_LOOKUP = 3'd0;
	localparam logic [2:0] ACT_MAP    = 3'd1;
	localparam logic [2:0] ACT_INVAL  = 3'd2;
	localparam logic [2:0] ACT_MARK   = 3'd3;
	localparam logic [2:0] ACT_TICK   = 3'd4;

	localparam logic [8:0] FRAME_NONE = 9'h1FF;
	localparam logic [7:0] AGE_TOP    = 8'h80;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] page;
		logic [7:0] frame;
	} cmd_t;

	typedef struct packed {
		logic signed [8:0] mapped_frame;
		logic              entry_valid;
		logic [7:0]        age_value;
	} res_t;

	localparam res_t RES_NONE = '{mapped_frame: FRAME_NONE, entry_valid: 1'b0,
		age_value: 8'd0};

endpackage

// ----- hdl/ptwa_cell.sv -----
// ----------------------------------------------------------------------------
// ptwa_cell
// One page table entry; applies each passing command and fills in the result
// when the command addresses this entry, then hands the beat to the next cell.
// ----------------------------------------------------------------------------
module ptwa_cell
	import ptwa_pkg::*;
#(
	parameter int IDX         = 0,
	parameter int FRAME_COUNT = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic vld_in,
	input  cmd_t cmd_in,
	input  res_t res_in,
	output logic vld_out,
	output cmd_t cmd_out,
	output res_t res_out
);

	logic       vld_q;
	cmd_t       cmd_q;
	res_t       res_q;
	logic [8:0] frame_q;
	logic       valid_q;
	logic       ref_q;
	logic [7:0] age_q;

	logic [8:0] frame_d;
	logic       valid_d;
	logic       ref_d;
	logic [7:0] age_d;
	logic       hit;

	assign hit = (32'(cmd_in.page) == IDX);

	always_comb begin
		frame_d = frame_q;
		valid_d = valid_q;
		ref_d   = ref_q;
		age_d   = age_q;
		if (cmd_in.action == ACT_TICK) begin
			if (valid_q) begin
				age_d = (age_q >> 1) | (ref_q ? AGE_TOP : 8'd0);
				ref_d = 1'b0;
			end
		end else if (hit) begin
			case (cmd_in.action)
				ACT_MAP: begin
					if (32'(cmd_in.frame) < FRAME_COUNT) begin
						frame_d = {1'b0, cmd_in.frame};
						valid_d = 1'b1;
						ref_d   = 1'b0;
						age_d   = 8'd0;
					end
				end
				ACT_INVAL: begin
					valid_d = 1'b0;
					frame_d = FRAME_NONE;
				end
				ACT_MARK: begin
					if (valid_q) begin
						ref_d = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= 1'b0;
			frame_q <= FRAME_NONE;
			valid_q <= 1'b0;
			ref_q   <= 1'b0;
			age_q   <= 8'd0;
		end else if (adv) begin
			vld_q <= vld_in;
			if (vld_in) begin
				frame_q <= frame_d;
				valid_q <= valid_d;
				ref_q   <= ref_d;
				age_q   <= age_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_q <= cmd_in;
			if (hit) begin
				res_q.mapped_frame <= valid_d ? frame_d : FRAME_NONE;
				res_q.entry_valid  <= valid_d;
				res_q.age_value    <= age_d;
			end else begin
				res_q <= res_in;
			end
		end
	end

	assign vld_out = vld_q;
	assign cmd_out = cmd_q;
	assign res_out = res_q;

endmodule

// ----- hdl/page_table_with_aging_unit.sv -----
// ----------------------------------------------------------------------------
// page_table_with_aging_unit
// Direct-indexed page table with per-entry aging counters, built as a chain
// of entry cells.
// ----------------------------------------------------------------------------
// Input channel s_*: one command beat (action in tuser, page and frame in
// tdata). Output channel m_*: one result beat per command (entry_valid in
// tuser, mapped_frame and age_value in tdata), in command order.
// Each command walks the chain one cell per cycle unless the chain holds; the
// cell that holds the addressed page applies the action and writes the result
// into the beat, and an aging tick updates every valid cell as it passes.
// The beat is registered in each of the TABLE_ENTRIES cells in turn. One beat
// per cycle unless stalled, as commands follow each other down the chain.
// The last cell is the output register. When the receiver stalls, the whole
// chain holds and s_tready drops until the result beat is taken.
// Reset: all entries invalid, frames -1, reference bits and counters zero,
// chain empty; no command is accepted while arst_n is low.
// ----------------------------------------------------------------------------
module page_table_with_aging_unit
	import ptwa_pkg::*;
#(
	parameter int TABLE_ENTRIES = 256,
	parameter int FRAME_COUNT   = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // page[7:0], frame[15:8]
	input  logic [2:0]  s_tuser,  // action[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // mapped_frame[8:0], age_value[16:9], zero[23:17]
	output logic [0:0]  m_tuser   // entry_valid[0]
);

	logic adv;
	logic vld_c [TABLE_ENTRIES+1];
	cmd_t cmd_c [TABLE_ENTRIES+1];
	res_t res_c [TABLE_ENTRIES+1];

	assign adv      = !vld_c[TABLE_ENTRIES] || m_tready;
	assign s_tready = adv && arst_n;

	assign vld_c[0] = s_tvalid;
	assign cmd_c[0] = '{action: s_tuser, page: s_tdata[7:0], frame: s_tdata[15:8]};
	assign res_c[0] = RES_NONE;

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		ptwa_cell #(
			.IDX        (i),
			.FRAME_COUNT(FRAME_COUNT)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.vld_in (vld_c[i]),
			.cmd_in (cmd_c[i]),
			.res_in (res_c[i]),
			.vld_out(vld_c[i+1]),
			.cmd_out(cmd_c[i+1]),
			.res_out(res_c[i+1])
		);
	end

	assign m_tvalid = vld_c[TABLE_ENTRIES];
	assign m_tdata  = {7'd0, res_c[TABLE_ENTRIES].age_value,
		res_c[TABLE_ENTRIES].mapped_frame};
	assign m_tuser  = res_c[TABLE_ENTRIES].entry_valid;

endmodule

// ----- hdl/ptwa_checker.sv -----
// ----------------------------------------------------------------------------
// ptwa_checker
// Port-level checks of the page table unit, bound to the top level.
// ----------------------------------------------------------------------------
module ptwa_checker
	import ptwa_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [0:0]  m_tuser
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("command taken while chain is stalled");

	a_invalid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[8:0] == FRAME_NONE)
		else $error("invalid entry reports a frame");

	a_valid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tdata[8] && m_tdata[23:17] == 7'd0)
		else $error("valid entry reports a negative frame");

endmodule

bind page_table_with_aging_unit ptwa_checker u_ptwa_checker (.*);

// ----- test/tb_page_table_with_aging_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_page_table_with_aging_unit
// Drives page table commands (lookup, map, invalidate, mark, aging tick and
// the spare action codes) into the unit. A behavioral copy of the table
// predicts each entry report, and every result beat is checked in order
// against it. The run goes through phases with and without random gaps on
// the command side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_page_table_with_aging_unit;
	import ptwa_pkg::*;

	localparam int TABLE_SIZE    = 256;
	localparam int FRAME_LIMIT   = 256;
	localparam int CHAIN_LATENCY = 256;
	localparam int IDLE_LIMIT    = 3000;

	localparam logic [2:0] ACT_SPARE5 = 3'd5;
	localparam logic [2:0] ACT_SPARE6 = 3'd6;
	localparam logic [2:0] ACT_SPARE7 = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // page[7:0], frame[15:8]
	logic [2:0]  s_tuser;   // action[2:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // mapped_frame[8:0], age_value[16:9], zero[23:17]
	logic [0:0]  m_tuser;   // entry_valid[0]

	logic [8:0] frame_tbl [TABLE_SIZE];
	logic       valid_tbl [TABLE_SIZE];
	logic       ref_tbl   [TABLE_SIZE];
	logic [7:0] age_tbl   [TABLE_SIZE];

	res_t entry_reports_q [$];

	int send_idle_pct;
	int stall_pct;
	int mismatches;
	int beats_in;
	int beats_out;
	int map_count;
	int tick_count;
	int idle_cycles;

	res_t exp_report;
	res_t got_report;

	page_table_with_aging_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic res_t apply_page_cmd(cmd_t c);
		res_t r;
		r = RES_NONE;
		if (c.action == ACT_TICK) begin
			for (int i = 0; i < TABLE_SIZE; i++) begin
				if (valid_tbl[i]) begin
					age_tbl[i] = {ref_tbl[i], age_tbl[i][7:1]};
					ref_tbl[i] = 1'b0;
				end
			end
		end else if (c.page < TABLE_SIZE) begin
			case (c.action)
				ACT_MAP: begin
					if (c.frame < FRAME_LIMIT) begin
						frame_tbl[c.page] = {1'b0, c.frame};
						valid_tbl[c.page] = 1'b1;
						ref_tbl[c.page]   = 1'b0;
						age_tbl[c.page]   = 8'd0;
					end
				end
				ACT_INVAL: begin
					valid_tbl[c.page] = 1'b0;
					frame_tbl[c.page] = FRAME_NONE;
				end
				ACT_MARK: begin
					if (valid_tbl[c.page])
						ref_tbl[c.page] = 1'b1;
				end
				default: ;
			endcase
		end
		if (c.page < TABLE_SIZE) begin
			if (valid_tbl[c.page]) begin
				r.mapped_frame = frame_tbl[c.page];
				r.entry_valid  = 1'b1;
			end
			r.age_value = age_tbl[c.page];
		end
		return r;
	endfunction

	task automatic send_cmd(input logic [2:0] act, input logic [7:0] pg, input logic [7:0] fr);
		cmd_t c;
		c.action = act;
		c.page   = pg;
		c.frame  = fr;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {fr, pg};
		s_tuser  <= act;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		entry_reports_q.push_back(apply_page_cmd(c));
		beats_in++;
		if (act == ACT_MAP)
			map_count++;
		if (act == ACT_TICK)
			tick_count++;
		@(negedge clk);
	endtask

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t mismatch: %s", $realtime, msg);
	endtask

	// result side: check each beat and watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				beats_out++;
				got_report.mapped_frame = m_tdata[8:0];
				got_report.age_value    = m_tdata[16:9];
				got_report.entry_valid  = m_tuser[0];
				if (entry_reports_q.size() == 0) begin
					note_mismatch($sformatf("unexpected beat frame=%0d valid=%0b age=%02h",
						got_report.mapped_frame, got_report.entry_valid,
						got_report.age_value));
				end else begin
					exp_report = entry_reports_q.pop_front();
					if (got_report.mapped_frame !== exp_report.mapped_frame ||
					    got_report.entry_valid !== exp_report.entry_valid ||
					    got_report.age_value !== exp_report.age_value)
						note_mismatch($sformatf(
							"beat %0d exp frame=%0d valid=%0b age=%02h, got frame=%0d valid=%0b age=%02h",
							beats_out, exp_report.mapped_frame, exp_report.entry_valid,
							exp_report.age_value, got_report.mapped_frame,
							got_report.entry_valid, got_report.age_value));
				end
			end
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout after %0d cycles without a beat", IDLE_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic test_directed();
		send_idle_pct = 0;
		stall_pct     = 0;
		send_cmd(ACT_LOOKUP, 8'd0,   8'd0);
		send_cmd(ACT_LOOKUP, 8'd255, 8'd255);
		send_cmd(ACT_MAP,    8'd0,   8'd0);
		send_cmd(ACT_MAP,    8'd255, 8'd255);
		send_cmd(ACT_MAP,    8'd170, 8'd85);
		send_cmd(ACT_MARK,   8'd0,   8'd0);
		// mark on an unmapped page is dropped
		send_cmd(ACT_MARK,   8'd7,   8'd0);
		send_cmd(ACT_TICK,   8'd85,  8'd170);
		send_cmd(ACT_LOOKUP, 8'd0,   8'd0);
		send_cmd(ACT_MARK,   8'd0,   8'd0);
		send_cmd(ACT_MARK,   8'd255, 8'd0);
		send_cmd(ACT_TICK,   8'd255, 8'd0);
		send_cmd(ACT_LOOKUP, 8'd0,   8'd0);
		// invalidate keeps the counter
		send_cmd(ACT_INVAL,  8'd0,   8'd0);
		send_cmd(ACT_MARK,   8'd0,   8'd0);
		send_cmd(ACT_TICK,   8'd1,   8'd0);
		send_cmd(ACT_LOOKUP, 8'd0,   8'd0);
		send_cmd(ACT_SPARE5, 8'd255, 8'd255);
		send_cmd(ACT_SPARE6, 8'd170, 8'd0);
		send_cmd(ACT_SPARE7, 8'd0,   8'd128);
		send_cmd(ACT_MAP,    8'd0,   8'd90);
		send_cmd(ACT_INVAL,  8'd3,   8'd0);
		send_cmd(ACT_MAP,    8'd255, 8'd0);
		send_cmd(ACT_LOOKUP, 8'd170, 8'd0);
	endtask

	task automatic test_random(input int count, input int idle_pct, input int stall_rate);
		int         sel;
		logic [2:0] act;
		logic [7:0] pg;
		send_idle_pct = idle_pct;
		stall_pct     = stall_rate;
		repeat (count) begin
			sel = $urandom_range(99);
			if (sel < 20)
				act = ACT_LOOKUP;
			else if (sel < 40)
				act = ACT_MARK;
			else if (sel < 55)
				act = ACT_MAP;
			else if (sel < 63)
				act = ACT_INVAL;
			else if (sel < 80)
				act = ACT_TICK;
			else if (sel < 87)
				act = ACT_SPARE5;
			else if (sel < 94)
				act = ACT_SPARE6;
			else
				act = ACT_SPARE7;
			// mostly a few hot pages so marks and ticks build up deep counters
			if ($urandom_range(99) < 70)
				pg = 8'($urandom_range(15));
			else
				pg = 8'($urandom_range(255));
			send_cmd(act, pg, 8'($urandom_range(255)));
		end
	endtask

	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		while (entry_reports_q.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = ACT_LOOKUP;
		m_tready      = 1'b0;
		send_idle_pct = 0;
		stall_pct     = 0;
		mismatches    = 0;
		beats_in      = 0;
		beats_out     = 0;
		map_count     = 0;
		tick_count    = 0;
		idle_cycles   = 0;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			frame_tbl[i] = FRAME_NONE;
			valid_tbl[i] = 1'b0;
			ref_tbl[i]   = 1'b0;
			age_tbl[i]   = 8'd0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_random(400, 0, 0);
		test_random(400, 58, 0);
		wait_for_drain();
		test_random(400, 0, 58);
		test_random(400, 21, 21);
		wait_for_drain();
		repeat (CHAIN_LATENCY + 20) @(posedge clk);

		if (entry_reports_q.size() != 0)
			note_mismatch($sformatf("%0d reports never arrived", entry_reports_q.size()));
		$display("run sent %0d commands (%0d maps, %0d aging ticks) and checked %0d result beats",
			beats_in, map_count, tick_count, beats_out);
		$display("mismatches: %0d", mismatches);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/ptwa_pkg.sv
hdl/ptwa_cell.sv
hdl/page_table_with_aging_unit.sv
hdl/ptwa_checker.sv
test/tb_page_table_with_aging_unit.sv
